// File: rtl/efc_pkg.sv
// Shared types and constants of the Ethernet frame classifier.
`timescale 1ns / 1ps

package efc_pkg;

    // Header bytes kept per frame: destination MAC up to the PFC enable vector.
    localparam int HDR_BYTES = 26;
    localparam int LEN_W     = 14;

    localparam logic [LEN_W-1:0] CNT_MAX = 14'd16383;

    // Length thresholds.
    localparam logic [LEN_W-1:0] LEN_DA       = 14'd6;
    localparam logic [LEN_W-1:0] LEN_TYPE     = 14'd14;
    localparam logic [LEN_W-1:0] LEN_LLC_TYPE = 14'd22;
    localparam logic [LEN_W-1:0] LEN_TAG      = 14'd16;
    localparam logic [LEN_W-1:0] LEN_LLC_TAG  = 14'd24;
    localparam logic [LEN_W-1:0] LEN_VEC      = 14'd18;
    localparam logic [LEN_W-1:0] LEN_LLC_VEC  = 14'd26;
    localparam logic [LEN_W-1:0] LEN_MIN      = 14'd64;
    localparam logic [LEN_W-1:0] LEN_BKT_LO   = 14'd1519;
    localparam logic [LEN_W-1:0] LEN_BKT_HI   = 14'd1535;
    localparam logic [LEN_W-1:0] LEN_JUMBO    = 14'd9104;

    // Address and protocol constants.
    localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] MAC_CTRL_DA = 48'h0180_C200_0001;
    localparam logic [15:0] ETYPE_MIN   = 16'h0800;
    localparam logic [15:0] TPID_CTAG   = 16'h8100;
    localparam logic [15:0] TPID_STAG   = 16'h9100;
    localparam logic [15:0] ETYPE_MCTRL = 16'h8808;
    localparam logic [15:0] OPC_PFC     = 16'h0101;
    localparam logic [15:0] OPC_PAUSE   = 16'h0001;
    localparam logic [8:0]  PRIO_NO_EN  = 9'h100;

    // Address class codes.
    localparam logic [1:0] ADDR_NONE  = 2'd0;
    localparam logic [1:0] ADDR_UCAST = 2'd1;
    localparam logic [1:0] ADDR_MCAST = 2'd2;
    localparam logic [1:0] ADDR_BCAST = 2'd3;

    // Frame descriptor handed from the front to the back.
    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] hdr;
        logic [LEN_W-1:0]          len;
    } desc_t;

    // Result item, first field in the highest bits.
    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic             oversized;
        logic             len_1519_to_1535;
        logic             exactly_64;
        logic             undersized;
        logic             pause_frame;
        logic             pfc_frame;
        logic [8:0]       priority_res;
        logic             vlan_tagged;
        logic [1:0]       addr_class;
    } result_t;

endpackage

// File: rtl/ethernet_frame_classifier_top.sv
// Top level of the Ethernet frame classifier.
`timescale 1ns / 1ps

// The classifier takes an Ethernet frame one byte per item on the slave
// stream (s_tdata holds the byte, s_tlast marks the closing byte) and gives
// one 32-bit result item on the master stream for each frame, carried by the
// item whose s_tlast is high. Other bytes give no result.
// Throughput is one byte per cycle while the queue has room. The front counts
// bytes and captures the first 26 header bytes; on the closing byte it pushes
// a frame descriptor into a short queue. The back decodes the descriptor into
// the result and holds it in an output register that drives m_tvalid; a
// descriptor is loaded there once the register is free or being read.
// When the receiver stalls, the result waits in the output register and
// further descriptors collect in the queue; bytes keep flowing until the
// queue is full, and s_tready then drops until the back drains an entry.
// Bytes that do not close a frame are held up only while the queue is full.
// Reset clears the byte count, the queue and the output valid flag, so the
// first byte after reset opens a new frame. Header bytes are not cleared;
// each header field is used only when the frame is long enough to hold it.
module ethernet_frame_classifier_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] addr_class, [2] vlan_tagged,
                                   // [11:3] priority_res, [12] pfc_frame,
                                   // [13] pause_frame, [14] undersized,
                                   // [15] exactly_64, [16] len_1519_to_1535,
                                   // [17] oversized, [31:18] frame_length
);
    import efc_pkg::*;

    desc_t   push_data;
    desc_t   pop_data;
    result_t out_data;
    logic    push_valid;
    logic    push_ready;
    logic    pop_valid;
    logic    pop_ready;

    // Front: byte counting and header capture.
    efc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Descriptor queue that decouples the two halves.
    efc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: header decode and the output register.
    efc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (pop_valid),
        .desc_ready (pop_ready),
        .desc       (pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = out_data;

endmodule

// File: rtl/efc_front.sv
// Front end: accepts frame bytes, counts them and captures the header.
`timescale 1ns / 1ps

module efc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              push_valid,
    input  logic              push_ready,
    output efc_pkg::desc_t    push_data
);
    import efc_pkg::*;

    logic [LEN_W-1:0]          cnt_reg;
    logic [LEN_W-1:0]          cnt_next;
    logic [LEN_W-1:0]          cnt_inc;
    logic [HDR_BYTES-1:0][7:0] hdr_reg;
    logic [HDR_BYTES-1:0][7:0] hdr_merged;
    logic                      accept;

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign cnt_inc    = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign push_valid = accept && in_last;

    // The closing byte is part of the header when the frame is short.
    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            hdr_merged[i] = (cnt_reg == LEN_W'(i)) ? in_byte : hdr_reg[i];
        end
    end

    assign push_data.hdr = hdr_merged;
    assign push_data.len = cnt_inc;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = in_last ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg <= hdr_merged;
        end
    end

endmodule

// File: rtl/efc_queue.sv
// Short descriptor queue between the front and the back.
`timescale 1ns / 1ps

module efc_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  efc_pkg::desc_t    push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output efc_pkg::desc_t    pop_data
);
    import efc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/efc_back.sv
// Back end: decodes a frame descriptor and holds the result item.
`timescale 1ns / 1ps

module efc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              desc_valid,
    output logic              desc_ready,
    input  efc_pkg::desc_t    desc,
    output logic              out_valid,
    input  logic              out_ready,
    output efc_pkg::result_t  out_data
);
    import efc_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_data_reg;
    result_t          res;
    logic             load;

    logic [LEN_W-1:0] len;
    logic [47:0]      da;
    logic [15:0]      tp_first;
    logic [15:0]      tp;
    logic [15:0]      opcode;
    logic [7:0]       tci_hi;
    logic [7:0]       pfc_vec;
    logic             llc;
    logic             have_type;
    logic             have_tag;
    logic             have_vec;
    logic             is_vlan;
    logic             is_mctrl;

    assign load       = desc_valid && (!out_valid_reg || out_ready);
    assign desc_ready = load;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Every header field is qualified by the frame length, so bytes left
    // over from an earlier frame never reach the result.
    always_comb
    begin
        len      = desc.len;
        da       = {desc.hdr[0], desc.hdr[1], desc.hdr[2],
                    desc.hdr[3], desc.hdr[4], desc.hdr[5]};
        tp_first = {desc.hdr[12], desc.hdr[13]};
        llc      = (tp_first < ETYPE_MIN);
        tp       = llc ? {desc.hdr[20], desc.hdr[21]} : tp_first;
        opcode   = llc ? {desc.hdr[22], desc.hdr[23]} : {desc.hdr[14], desc.hdr[15]};
        tci_hi   = llc ? desc.hdr[22] : desc.hdr[14];
        pfc_vec  = llc ? desc.hdr[25] : desc.hdr[17];

        have_type = (len >= LEN_TYPE) && (!llc || (len >= LEN_LLC_TYPE));
        have_tag  = llc ? (len >= LEN_LLC_TAG) : (len >= LEN_TAG);
        have_vec  = llc ? (len >= LEN_LLC_VEC) : (len >= LEN_VEC);
        is_vlan   = have_type && ((tp == TPID_CTAG) || (tp == TPID_STAG));
        is_mctrl  = have_type && !is_vlan && have_tag &&
                    (tp == ETYPE_MCTRL) && (da == MAC_CTRL_DA);

        res = '0;
        if (len < LEN_DA)
        begin
            res.addr_class = ADDR_NONE;
        end
        else if (da == MAC_BCAST)
        begin
            res.addr_class = ADDR_BCAST;
        end
        else if (da[40])
        begin
            res.addr_class = ADDR_MCAST;
        end
        else
        begin
            res.addr_class = ADDR_UCAST;
        end

        if (is_vlan && have_tag)
        begin
            res.vlan_tagged  = 1'b1;
            res.priority_res = {6'd0, tci_hi[7:5]};
        end
        else if (is_mctrl && (opcode == OPC_PFC) && have_vec)
        begin
            res.pfc_frame    = 1'b1;
            res.priority_res = (pfc_vec == 8'd0) ? PRIO_NO_EN : {1'b0, pfc_vec};
        end
        else if (is_mctrl && (opcode == OPC_PAUSE))
        begin
            res.pause_frame = 1'b1;
        end

        // A frame cut short of a header field is always below 64 bytes.
        res.undersized       = (len < LEN_MIN);
        res.exactly_64       = (len == LEN_MIN);
        res.len_1519_to_1535 = (len >= LEN_BKT_LO) && (len <= LEN_BKT_HI);
        res.oversized        = (len > LEN_JUMBO);
        res.frame_length     = len;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// File: rtl/efc_checker.sv
// Port-level checks of the Ethernet frame classifier and their binding.
`timescale 1ns / 1ps

module efc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The undersized flag agrees with the reported length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14] == (m_tdata[31:18] < 14'd64)))
        else $error("undersized flag disagrees with frame length");

    // A frame never counts zero bytes and is never both PFC and PAUSE.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:18] != 14'd0) && !(m_tdata[12] && m_tdata[13]))
        else $error("bad length or conflicting control flags");

    // No address class is given only for frames too short to hold the address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == 2'd0) |-> (m_tdata[31:18] < 14'd6))
        else $error("address class missing on a long frame");

    // Priority is only set on tagged or PFC frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] && !m_tdata[12] |-> (m_tdata[11:3] == 9'd0))
        else $error("priority set on a frame without tag or PFC");

endmodule

bind ethernet_frame_classifier_top efc_checker u_efc_checker (.*);

// File: tb/sv/ethernet_frame_classifier_top_tb.sv
// Testbench of the Ethernet frame classifier: directed and random frames checked by a predictor.
`timescale 1ns / 1ps

module ethernet_frame_classifier_top_tb;

    import efc_pkg::*;

    // The receiver holds off this long once, so that the result queue fills
    // and the block has to stall its byte input.
    localparam int HOLD_CYCLES   = 300;
    // Cycles with no item accepted on either side before the run is called hung.
    localparam int IDLE_LIMIT    = 5000;
    // The block raises m_tvalid once the descriptor of the closing byte is
    // loaded into the output register; the final pause is comfortably longer.
    localparam int DRAIN_CYCLES  = 20;
    // The random part stops once this many bytes have been sent.
    localparam int RAND_BYTES    = 650;

    // Frame templates. The header is built from one of these and the bytes
    // past the header are random.
    typedef enum logic [3:0] {
        FRM_RAW,         // every header byte random
        FRM_BCAST,       // broadcast DA, IPv4 EtherType
        FRM_MCAST,       // group bit set in the DA
        FRM_UCAST,       // group bit clear in the DA
        FRM_CTAG,        // TPID 0x8100 and a random TCI
        FRM_STAG,        // TPID 0x9100 and a random TCI
        FRM_PAUSE,       // MAC control PAUSE
        FRM_PFC,         // priority flow control with a random enable vector
        FRM_PFC_NOEN,    // priority flow control with an all-zero enable byte
        FRM_CTRL_OTHER,  // MAC control DA and EtherType, unknown opcode
        FRM_CTRL_BAD_DA  // PFC opcode and EtherType behind a unicast DA
    } frame_kind_e;

    // One row of the directed table. When known_result is set, the result is
    // typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        frame_kind_e kind;
        logic        llc;
        int          len;
        logic        known_result;
        result_t     want;
    } frame_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Predictor state: bytes of the current frame and the copy of its header.
    logic [LEN_W-1:0] bytes_seen;
    logic [7:0]       hdr_copy [HDR_BYTES];

    // Header template of the frame being sent.
    logic [7:0] hdr_tpl [HDR_BYTES];

    result_t    pending_results [$];
    frame_row_t directed_rows [$];

    int  mismatches   = 0;
    int  idle_cycles  = 0;
    int  burst_left   = 0;
    bit  hold_req     = 1'b0;

    ethernet_frame_classifier_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Builds a result with only the address class, the size flags and the
    // length set, which is all a row with a typed result needs.
    function automatic result_t size_result(input logic [1:0] addr, input logic under,
                                            input logic is_64, input logic over,
                                            input logic [LEN_W-1:0] len);
        result_t r;
        r                  = '0;
        r.addr_class       = addr;
        r.undersized       = under;
        r.exactly_64       = is_64;
        r.oversized        = over;
        r.frame_length     = len;
        return r;
    endfunction

    task automatic add_row(input frame_kind_e kind, input logic llc, input int len,
                           input logic known, input result_t want);
        frame_row_t row;
        row.kind         = kind;
        row.llc          = llc;
        row.len          = len;
        row.known_result = known;
        row.want         = want;
        directed_rows.push_back(row);
    endtask

    // Predictor: takes one accepted byte. On the closing byte it classifies
    // the header copy of the frame and hands back the result.
    task automatic classify_byte(input logic [7:0] d, input logic is_last,
                                 output logic done, output result_t r);
        int          len;
        int          pos;
        logic        ok;
        logic [47:0] da;
        logic [15:0] etype;
        logic [15:0] opc;
        r    = '0;
        done = 1'b0;
        if (bytes_seen < HDR_BYTES)
            hdr_copy[bytes_seen] = d;
        if (bytes_seen < CNT_MAX)
            bytes_seen = bytes_seen + 1'b1;
        if (is_last)
        begin
            done       = 1'b1;
            len        = int'(bytes_seen);
            bytes_seen = '0;
            ok         = 1'b1;
            // Each decision stops as soon as the frame ends before the field
            // it needs; flags found so far are kept.
            if (len < LEN_DA)
                ok = 1'b0;
            else
            begin
                da = {hdr_copy[0], hdr_copy[1], hdr_copy[2],
                      hdr_copy[3], hdr_copy[4], hdr_copy[5]};
                if (da == MAC_BCAST)
                    r.addr_class = ADDR_BCAST;
                else if (hdr_copy[0][0])
                    r.addr_class = ADDR_MCAST;
                else
                    r.addr_class = ADDR_UCAST;
                if (len < LEN_TYPE)
                    ok = 1'b0;
                else
                begin
                    etype = {hdr_copy[12], hdr_copy[13]};
                    pos   = 14;
                    // A length field means LLC/SNAP; the real EtherType sits
                    // eight bytes further on.
                    if (etype < ETYPE_MIN)
                    begin
                        if (len < LEN_LLC_TYPE)
                            ok = 1'b0;
                        else
                        begin
                            etype = {hdr_copy[20], hdr_copy[21]};
                            pos   = 22;
                        end
                    end
                    if (ok)
                    begin
                        if (etype == TPID_CTAG || etype == TPID_STAG)
                        begin
                            if (len < pos + 2)
                                ok = 1'b0;
                            else
                            begin
                                r.vlan_tagged  = 1'b1;
                                r.priority_res = {6'd0, hdr_copy[pos][7:5]};
                            end
                        end
                        else if (etype == ETYPE_MCTRL && da == MAC_CTRL_DA)
                        begin
                            if (len < pos + 2)
                                ok = 1'b0;
                            else
                            begin
                                opc = {hdr_copy[pos], hdr_copy[pos + 1]};
                                if (opc == OPC_PFC)
                                begin
                                    // PFC without its enable vector is no PFC.
                                    if (len < pos + 4)
                                        ok = 1'b0;
                                    else
                                    begin
                                        r.pfc_frame    = 1'b1;
                                        r.priority_res = (hdr_copy[pos + 3] == 8'h00) ?
                                                         PRIO_NO_EN :
                                                         {1'b0, hdr_copy[pos + 3]};
                                    end
                                end
                                else if (opc == OPC_PAUSE)
                                    r.pause_frame = 1'b1;
                            end
                        end
                    end
                end
            end
            r.undersized = !ok || (len < LEN_MIN);
            if (ok)
            begin
                r.exactly_64       = (len == LEN_MIN);
                r.len_1519_to_1535 = (len >= LEN_BKT_LO) && (len <= LEN_BKT_HI);
                r.oversized        = (len > LEN_JUMBO);
            end
            r.frame_length = LEN_W'(len);
        end
    endtask

    // Fills the header template for one frame kind, with or without an
    // LLC/SNAP header in front of the EtherType.
    task automatic fill_header(input frame_kind_e kind, input logic llc);
        int          tpos;
        logic [15:0] lenfld;
        logic [15:0] etype;
        logic [15:0] opc;
        for (int i = 0; i < HDR_BYTES; i++)
            hdr_tpl[i] = 8'($urandom);
        case (kind)
            FRM_BCAST:
                for (int i = 0; i < 6; i++)
                    hdr_tpl[i] = 8'hFF;
            FRM_MCAST:
                hdr_tpl[0][0] = 1'b1;
            FRM_UCAST, FRM_CTRL_BAD_DA:
                hdr_tpl[0][0] = 1'b0;
            FRM_PAUSE, FRM_PFC, FRM_PFC_NOEN, FRM_CTRL_OTHER:
                for (int i = 0; i < 6; i++)
                    hdr_tpl[i] = MAC_CTRL_DA[47 - 8 * i -: 8];
            default:
                ;
        endcase
        tpos = llc ? 20 : 12;
        if (llc)
        begin
            // Length field values right at both ends of the LLC range.
            case ($urandom_range(0, 3))
                0:       lenfld = 16'h0000;
                1:       lenfld = ETYPE_MIN - 16'd1;
                default: lenfld = 16'($urandom_range(0, ETYPE_MIN - 1));
            endcase
            hdr_tpl[12] = lenfld[15:8];
            hdr_tpl[13] = lenfld[7:0];
        end
        case (kind)
            FRM_RAW:                       etype = {hdr_tpl[tpos], hdr_tpl[tpos + 1]};
            FRM_BCAST, FRM_MCAST, FRM_UCAST: etype = ETYPE_MIN;
            FRM_CTAG:                      etype = TPID_CTAG;
            FRM_STAG:                      etype = TPID_STAG;
            default:                       etype = ETYPE_MCTRL;
        endcase
        hdr_tpl[tpos]     = etype[15:8];
        hdr_tpl[tpos + 1] = etype[7:0];
        opc = {hdr_tpl[tpos + 2], hdr_tpl[tpos + 3]};
        case (kind)
            FRM_PAUSE:                                opc = OPC_PAUSE;
            FRM_PFC, FRM_PFC_NOEN, FRM_CTRL_BAD_DA:   opc = OPC_PFC;
            FRM_CTRL_OTHER:                           opc = opc | 16'h0200;
            default:                                  ;
        endcase
        hdr_tpl[tpos + 2] = opc[15:8];
        hdr_tpl[tpos + 3] = opc[7:0];
        if (kind == FRM_PFC_NOEN)
            hdr_tpl[tpos + 5] = 8'h00;
    endtask

    // Offers one byte and returns at the edge that accepts it. The sender
    // works in bursts; between bursts it may drop tvalid for a random gap.
    task automatic send_byte(input logic [7:0] d, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Sends a whole frame. Every accepted byte goes through the predictor;
    // on the closing byte the expected result is queued, typed or predicted.
    task automatic send_frame(input frame_kind_e kind, input logic llc, input int len,
                              input logic known, input result_t want);
        logic [7:0] d;
        logic       done;
        result_t    predicted;
        fill_header(kind, llc);
        for (int i = 0; i < len; i++)
        begin
            d = (i < HDR_BYTES) ? hdr_tpl[i] : 8'($urandom);
            send_byte(d, i == len - 1);
            classify_byte(d, i == len - 1, done, predicted);
            if (done)
                pending_results.push_back(known ? want : predicted);
        end
    endtask

    // Most random frames are short so that they end inside the header and
    // cut each decision short; a few land on the size buckets.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 30);
        else if (r < 88)
            return $urandom_range(31, 100);
        else if (r < 96)
            return $urandom_range(62, 66);
        else
            return $urandom_range(1515, 1540);
    endfunction

    task automatic cmp_field(input string name, input int unsigned want,
                             input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Result checker and idle watchdog. Both sample the pre-edge values.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;

            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %h", $time, m_tdata);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    cmp_field("addr_class",       want.addr_class,       got.addr_class);
                    cmp_field("vlan_tagged",      want.vlan_tagged,      got.vlan_tagged);
                    cmp_field("priority_res",     want.priority_res,     got.priority_res);
                    cmp_field("pfc_frame",        want.pfc_frame,        got.pfc_frame);
                    cmp_field("pause_frame",      want.pause_frame,      got.pause_frame);
                    cmp_field("undersized",       want.undersized,       got.undersized);
                    cmp_field("exactly_64",       want.exactly_64,       got.exactly_64);
                    cmp_field("len_1519_to_1535", want.len_1519_to_1535, got.len_1519_to_1535);
                    cmp_field("oversized",        want.oversized,        got.oversized);
                    cmp_field("frame_length",     want.frame_length,     got.frame_length);
                end
            end
        end
    end

    // Receiver. It switches between stall patterns in phases of random
    // length, and once holds off for a long stretch when asked to.
    initial
    begin
        int mode;
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                n    = $urandom_range(5, 60);
                for (int k = 0; k < n; k++)
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= (k % 4 == 0);
                        default: m_tready <= ($urandom_range(0, 7) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random frames.
    initial
    begin
        int rand_bytes;
        int len;
        frame_row_t row;

        for (int i = 0; i < HDR_BYTES; i++)
            hdr_copy[i] = 8'h00;
        bytes_seen = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: the shortest frames, header fields cut just before
        // and just after them, tag, PAUSE and PFC frames with and without LLC,
        // and the size buckets and saturation.
        add_row(FRM_RAW,         1'b0, 1,     1'b1,
                size_result(ADDR_NONE, 1'b1, 1'b0, 1'b0, 14'd1));
        add_row(FRM_BCAST,       1'b0, 5,     1'b1,
                size_result(ADDR_NONE, 1'b1, 1'b0, 1'b0, 14'd5));
        add_row(FRM_BCAST,       1'b0, 6,     1'b1,
                size_result(ADDR_BCAST, 1'b1, 1'b0, 1'b0, 14'd6));
        add_row(FRM_MCAST,       1'b0, 13,    1'b0, '0);
        add_row(FRM_BCAST,       1'b0, 64,    1'b1,
                size_result(ADDR_BCAST, 1'b0, 1'b1, 1'b0, 14'd64));
        add_row(FRM_UCAST,       1'b0, 65,    1'b0, '0);
        add_row(FRM_CTAG,        1'b0, 15,    1'b0, '0);
        add_row(FRM_CTAG,        1'b0, 16,    1'b0, '0);
        add_row(FRM_STAG,        1'b0, 70,    1'b0, '0);
        add_row(FRM_UCAST,       1'b1, 21,    1'b0, '0);
        add_row(FRM_CTAG,        1'b1, 23,    1'b0, '0);
        add_row(FRM_STAG,        1'b1, 24,    1'b0, '0);
        add_row(FRM_PAUSE,       1'b0, 15,    1'b0, '0);
        add_row(FRM_PAUSE,       1'b0, 60,    1'b0, '0);
        add_row(FRM_PFC,         1'b0, 17,    1'b0, '0);
        add_row(FRM_PFC,         1'b0, 18,    1'b0, '0);
        add_row(FRM_PFC_NOEN,    1'b0, 64,    1'b0, '0);
        add_row(FRM_PFC,         1'b1, 26,    1'b0, '0);
        add_row(FRM_PAUSE,       1'b1, 64,    1'b0, '0);
        add_row(FRM_CTRL_OTHER,  1'b0, 64,    1'b0, '0);
        add_row(FRM_CTRL_BAD_DA, 1'b0, 64,    1'b0, '0);
        add_row(FRM_UCAST,       1'b0, 1519,  1'b0, '0);
        add_row(FRM_UCAST,       1'b0, 1535,  1'b0, '0);
        add_row(FRM_RAW,         1'b0, 9105,  1'b0, '0);
        // Longer than the counter can hold: the length saturates.
        add_row(FRM_UCAST,       1'b0, 16390, 1'b1,
                size_result(ADDR_UCAST, 1'b0, 1'b0, 1'b1, CNT_MAX));

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_frame(row.kind, row.llc, row.len, row.known_result, row.want);
        end

        // Random part. The long receiver hold-off starts here while the
        // sender keeps offering short frames.
        hold_req    = 1'b1;
        rand_bytes  = 0;
        while (rand_bytes < RAND_BYTES)
        begin
            len = pick_length();
            send_frame(frame_kind_e'($urandom_range(0, FRM_CTRL_BAD_DA)),
                       ($urandom_range(0, 3) == 0), len, 1'b0, '0);
            rand_bytes  = rand_bytes + len;
        end
        s_tvalid <= 1'b0;

        // Wait for every expected result; the watchdog guards this loop.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatches = mismatches + 1;
        end
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
